>>> hw/rtl/lfc_pkg.sv
package lfc_pkg;

    localparam logic [15:0] CRC_POLY         = 16'h8005;
    localparam logic [7:0]  MIN_COUNT        = 8'd3;
    localparam int          MAX_RESP_LEN_DEF = 64;
    localparam int          OQ_DEPTH         = 4;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_DATA  = 2'd1,
        PH_RXLO  = 2'd2,
        PH_RXHI  = 2'd3
    } phase_t;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_CRC     = 1'b1
    } kind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       crc_ok;
        logic       length_ok;
        logic       bad_count;
        logic [7:0] resp_len;
        logic       last;
    } res_t;

    // data bits enter lsb first, register shifts msb out
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb = b[i] ^ c[15];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/lfc_frame.sv
module lfc_frame
    import lfc_pkg::*;
#(
    parameter int MAX_RESP_LEN = MAX_RESP_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       mode,
    output logic [1:0] res_cnt,
    output res_t       res0,
    output res_t       res1
);

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  left_reg, left_next;
    logic        fmode_reg, fmode_next;
    logic [7:0]  rxlo_reg, rxlo_next;
    logic [7:0]  flen_reg, flen_next;

    logic [15:0] crc_upd;
    logic [7:0]  left_dec;
    logic [7:0]  rlen;

    assign crc_upd  = crc_byte((phase_reg == PH_COUNT) ? 16'h0000 : crc_reg, data_byte);
    assign left_dec = (phase_reg == PH_COUNT) ? (data_byte - MIN_COUNT) : (left_reg - 8'd1);
    assign rlen     = flen_reg - MIN_COUNT;

    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        left_next  = left_reg;
        fmode_next = fmode_reg;
        rxlo_next  = rxlo_reg;
        flen_next  = flen_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    if (data_byte >= MIN_COUNT)
                    begin
                        fmode_next = mode;
                        flen_next  = data_byte;
                        crc_next   = crc_upd;
                        left_next  = left_dec;
                        if (left_dec != 8'd0)
                        begin
                            phase_next = PH_DATA;
                        end
                        else if (!mode)
                        begin
                            phase_next = PH_RXLO;
                        end
                    end
                end
                PH_DATA:
                begin
                    crc_next  = crc_upd;
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = fmode_reg ? PH_COUNT : PH_RXLO;
                    end
                end
                PH_RXLO:
                begin
                    rxlo_next  = data_byte;
                    phase_next = PH_RXHI;
                end
                PH_RXHI:
                begin
                    phase_next = PH_COUNT;
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        res_cnt = 2'd0;
        res0    = '0;
        res1    = '0;
        res0.kind     = KIND_CRC;
        res0.out_byte = crc_upd[7:0];
        res1.kind     = KIND_CRC;
        res1.out_byte = crc_upd[15:8];
        res1.last     = 1'b1;
        if (step)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    if (data_byte < MIN_COUNT)
                    begin
                        res_cnt        = 2'd1;
                        res0           = '0;
                        res0.kind      = KIND_VERDICT;
                        res0.bad_count = 1'b1;
                        res0.last      = 1'b1;
                    end
                    else if (left_dec == 8'd0 && mode)
                    begin
                        res_cnt = 2'd2;
                    end
                end
                PH_DATA:
                begin
                    if (left_dec == 8'd0 && fmode_reg)
                    begin
                        res_cnt = 2'd2;
                    end
                end
                PH_RXLO:
                begin
                    res_cnt = 2'd0;
                end
                PH_RXHI:
                begin
                    res_cnt        = 2'd1;
                    res0           = '0;
                    res0.kind      = KIND_VERDICT;
                    res0.crc_ok    = (rxlo_reg == crc_reg[7:0]) && (data_byte == crc_reg[15:8]);
                    res0.length_ok = (rlen <= 8'(MAX_RESP_LEN));
                    res0.resp_len  = rlen;
                    res0.last      = 1'b1;
                end
                default:
                begin
                    res_cnt = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT;
            crc_reg   <= '0;
            left_reg  <= '0;
            fmode_reg <= 1'b0;
            rxlo_reg  <= '0;
            flen_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            left_reg  <= left_next;
            fmode_reg <= fmode_next;
            rxlo_reg  <= rxlo_next;
            flen_reg  <= flen_next;
        end
    end

endmodule

>>> hw/rtl/lfc_outq.sv
module lfc_outq
    import lfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  res_t       push0,
    input  res_t       push1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_stall,
    output res_t       head
);

    localparam int PW = $clog2(OQ_DEPTH);

    res_t          mem [OQ_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (cnt_reg <= (PW+1)'(OQ_DEPTH - 2));
    assign head      = mem[rd_reg];

    assign wr_next  = wr_reg + PW'(push_cnt);
    assign rd_next  = rd_reg + PW'(pop);
    assign cnt_next = cnt_reg + (PW+1)'(push_cnt) - (PW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_reg + PW'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/length_framed_crc16_checker.sv
// An input byte is registered; its result beats go to a 4-entry result queue.
// Throughput: one byte per cycle while that queue has room; the end of a
// generate frame emits two beats (low then high CRC byte) from one input byte.
// Reset (rst_n low, async): waits for a count byte, CRC cleared, queue empty.
module length_framed_crc16_checker
    import lfc_pkg::*;
#(
    parameter int MAX_RESP_LEN = MAX_RESP_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       mode,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] out_byte,
    output logic       crc_ok,
    output logic       length_ok,
    output logic       bad_count,
    output logic [7:0] resp_len,
    output logic       last
);

    logic       vld_reg, vld_next;
    logic [7:0] byte_reg;
    logic       mode_reg;
    logic       room;
    logic       step;
    logic [1:0] res_cnt;
    res_t       res0, res1, head;

    assign step     = vld_reg && room;
    assign in_stall = vld_reg && !room;
    assign vld_next = in_stall ? vld_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            mode_reg <= mode;
        end
    end

    lfc_frame #(
        .MAX_RESP_LEN(MAX_RESP_LEN)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_reg),
        .mode      (mode_reg),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    lfc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind      = head.kind;
    assign out_byte  = head.out_byte;
    assign crc_ok    = head.crc_ok;
    assign length_ok = head.length_ok;
    assign bad_count = head.bad_count;
    assign resp_len  = head.resp_len;
    assign last      = head.last;

endmodule
